// ===== hw/rtl/kpt_pkg.sv =====
package kpt_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int HANDLE_BITS_DEFAULT = 16;

	localparam int LABEL_W = 8;
	localparam int KEY_W = 32;
	localparam int HANDLE_PORT_W = 16;
	localparam int STATUS_W = 3;

	// Command codes
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_LIST = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LISTED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd5;

	// Label stored when label mode is off
	localparam logic [LABEL_W-1:0] LABEL_NONE = 8'hFF;

	// Configuration register indexes
	localparam logic REG_LABEL_MODE = 1'b0;

endpackage

// ===== hw/rtl/key_pair_lookup_or_insert_table_unit.sv =====
// Table of up to DEPTH entries (label, two 32-bit keys, handle) kept in insertion order in
// one synchronous single-port memory with a registered read. A lookup request scans the
// entries from the oldest, one memory read per cycle: a hit answers for the first matching
// entry, a miss once all n stored entries are read (the append write takes place in the
// answering cycle). A list request gives one result per cycle while the output is not
// stalled, after a first memory read, or a single result on an empty table. The block
// takes one request at a time; a finished result waits in the output register while the
// next request is accepted. The memory needs no clearing after reset: only entries below
// the entry count are ever read.
module key_pair_lookup_or_insert_table_unit
	import kpt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,

	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       cmd,
	input  logic signed [LABEL_W-1:0]  label,
	input  logic signed [KEY_W-1:0]    key_first,
	input  logic signed [KEY_W-1:0]    key_second,
	input  logic                       learn,
	input  logic [HANDLE_PORT_W-1:0]   new_handle,

	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [HANDLE_PORT_W-1:0]   handle_out,
	output logic signed [KEY_W-1:0]    key_first_out,
	output logic signed [KEY_W-1:0]    key_second_out,
	output logic signed [LABEL_W-1:0]  label_out,
	output logic                       last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	// only the low min(HANDLE_BITS, 16) bits of a handle are stored and reach the ports
	localparam int HW = (HANDLE_BITS < HANDLE_PORT_W) ? HANDLE_BITS : HANDLE_PORT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_MISS = 3'd2;
	localparam logic [2:0] S_LIST = 3'd3;
	localparam logic [2:0] S_EMPTY = 3'd4;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [KEY_W-1:0]   key_first;
		logic [KEY_W-1:0]   key_second;
		logic [HW-1:0]      handle;
	} entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [HANDLE_PORT_W-1:0] handle;
		logic [KEY_W-1:0]         key_first;
		logic [KEY_W-1:0]         key_second;
		logic [LABEL_W-1:0]       label;
		logic                     last;
	} result_t;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] count_q, count_d;
	logic          label_mode_q;

	logic                 req_cmd_q;
	logic [LABEL_W-1:0]   req_label_q;
	logic [KEY_W-1:0]     req_key_first_q;
	logic [KEY_W-1:0]     req_key_second_q;
	logic                 req_learn_q;
	logic [HW-1:0]        req_handle_q;
	logic                 req_load;

	entry_t        mem_q [DEPTH];
	entry_t        rd_data_q;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          mem_we;

	result_t       out_q, out_d;
	logic          out_valid_q;
	logic          out_load;
	logic          out_free;

	logic          hit;
	logic          last_idx;
	logic          full;
	logic          cfg_we;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_LABEL_MODE) begin
			prdata[0] = label_mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_mode_q <= 1'b0;
		end else if (cfg_we && paddr[2] == REG_LABEL_MODE) begin
			label_mode_q <= pwdata[0];
		end
	end

	// ---------------- entry memory ----------------
	// Reads and the append write never fall in the same cycle, so no forwarding is needed.
	assign wr_data.label = label_mode_q ? req_label_q : LABEL_NONE;
	assign wr_data.key_first = req_key_first_q;
	assign wr_data.key_second = req_key_second_q;
	assign wr_data.handle = req_handle_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[count_q[AW-1:0]] <= wr_data;
		end
	end

	// read data holds until the next read, so a stalled output can wait on it
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// ---------------- control ----------------
	assign req_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !rsp_stall;
	assign last_idx = ((CW'(idx_q) + CW'(1)) == count_q);
	assign full = (count_q == CW'(DEPTH));
	assign hit = (!label_mode_q || rd_data_q.label == req_label_q)
		&& rd_data_q.key_first == req_key_first_q
		&& rd_data_q.key_second == req_key_second_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		count_d = count_q;
		req_load = 1'b0;
		rd_en = 1'b0;
		rd_addr = idx_q + AW'(1);
		mem_we = 1'b0;
		out_load = 1'b0;
		out_d = '0;
		out_d.last = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_load = 1'b1;
					idx_d = '0;
					if (count_q == '0) begin
						state_d = (cmd == CMD_LIST) ? S_EMPTY : S_MISS;
					end else begin
						rd_en = 1'b1;
						rd_addr = '0;
						state_d = (cmd == CMD_LIST) ? S_LIST : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (out_free) begin
						out_load = 1'b1;
						out_d.status = ST_FOUND;
						out_d.handle = HANDLE_PORT_W'(rd_data_q.handle);
						state_d = S_IDLE;
					end
				end else if (last_idx) begin
					state_d = S_MISS;
				end else begin
					rd_en = 1'b1;
					idx_d = idx_q + AW'(1);
				end
			end
			S_MISS: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
					if (!req_learn_q) begin
						out_d.status = ST_ABSENT;
					end else if (full) begin
						out_d.status = ST_FULL;
					end else begin
						mem_we = 1'b1;
						count_d = count_q + CW'(1);
						out_d.status = ST_INSERTED;
						out_d.handle = HANDLE_PORT_W'(req_handle_q);
					end
				end
			end
			S_LIST: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d.status = ST_LISTED;
					out_d.handle = HANDLE_PORT_W'(rd_data_q.handle);
					out_d.key_first = rd_data_q.key_first;
					out_d.key_second = rd_data_q.key_second;
					out_d.label = rd_data_q.label;
					out_d.last = last_idx;
					if (last_idx) begin
						state_d = S_IDLE;
					end else begin
						rd_en = 1'b1;
						idx_d = idx_q + AW'(1);
					end
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d.status = ST_EMPTY;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_load) begin
			req_cmd_q <= cmd;
			req_label_q <= label;
			req_key_first_q <= key_first;
			req_key_second_q <= key_second;
			req_learn_q <= learn;
			req_handle_q <= new_handle[HW-1:0];
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign status = out_q.status;
	assign handle_out = out_q.handle;
	assign key_first_out = out_q.key_first;
	assign key_second_out = out_q.key_second;
	assign label_out = out_q.label;
	assign last = out_q.last;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (count_q < CW'(DEPTH)) && state_q == S_MISS && req_cmd_q == CMD_LOOKUP)
		else $error("append without room or outside miss handling");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> count_q == $past(count_q) + CW'(1))
		else $error("entry count not advanced by append");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_LIST) |-> CW'(idx_q) < count_q)
		else $error("scan index past stored entries");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rsp_stall |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kpt_pkg::*;

	localparam int NO_ACCEPT_LIMIT = 3000;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_CYCLES = 2 * DEPTH_DEFAULT + 10;
	localparam int RANDOM_PER_SEGMENT = 64;
	localparam logic [2:0] LABEL_MODE_ADDR = 3'(4 * int'(REG_LABEL_MODE));

	typedef struct {
		logic                      cmd;
		logic signed [LABEL_W-1:0] label;
		logic signed [KEY_W-1:0]   key_first;
		logic signed [KEY_W-1:0]   key_second;
		logic                      learn;
		logic [HANDLE_PORT_W-1:0]  new_handle;
	} table_req_t;

	typedef struct {
		logic [STATUS_W-1:0]       status;
		logic [HANDLE_PORT_W-1:0]  handle;
		logic signed [KEY_W-1:0]   key_first;
		logic signed [KEY_W-1:0]   key_second;
		logic signed [LABEL_W-1:0] label;
		logic                      last;
	} table_rsp_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [2:0]                 paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       req_valid = 1'b0;
	logic                       req_stall;
	logic                       cmd = CMD_LOOKUP;
	logic signed [LABEL_W-1:0]  label = '0;
	logic signed [KEY_W-1:0]    key_first = '0;
	logic signed [KEY_W-1:0]    key_second = '0;
	logic                       learn = 1'b0;
	logic [HANDLE_PORT_W-1:0]   new_handle = '0;
	logic                       rsp_valid;
	logic                       rsp_stall = 1'b0;
	logic [STATUS_W-1:0]        status;
	logic [HANDLE_PORT_W-1:0]   handle_out;
	logic signed [KEY_W-1:0]    key_first_out;
	logic signed [KEY_W-1:0]    key_second_out;
	logic signed [LABEL_W-1:0]  label_out;
	logic                       last;

	table_req_t pending_reqs[$];
	table_req_t seen_keys[$];
	table_rsp_t expected_rsps[$];
	table_rsp_t rsp_exp;

	// Shadow copy of the table contents
	logic signed [LABEL_W-1:0]  shadow_label[DEPTH_DEFAULT];
	logic signed [KEY_W-1:0]    shadow_key_first[DEPTH_DEFAULT];
	logic signed [KEY_W-1:0]    shadow_key_second[DEPTH_DEFAULT];
	logic [HANDLE_PORT_W-1:0]   shadow_handle[DEPTH_DEFAULT];
	int                         shadow_count = 0;
	logic                       shadow_label_mode = 1'b0;

	int  sender_idle_pct = 0;
	int  receiver_idle_pct = 0;
	int  hold_trigger = 0;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  quiet_cycles = 0;
	int  errors = 0;
	bit  req_taken = 1'b0;

	key_pair_lookup_or_insert_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .cmd(cmd), .label(label),
		.key_first(key_first), .key_second(key_second), .learn(learn),
		.new_handle(new_handle),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
		.handle_out(handle_out), .key_first_out(key_first_out),
		.key_second_out(key_second_out), .label_out(label_out), .last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void push_rsp(logic [STATUS_W-1:0] st, logic [HANDLE_PORT_W-1:0] h,
			logic signed [KEY_W-1:0] k1, logic signed [KEY_W-1:0] k2,
			logic signed [LABEL_W-1:0] lb, logic lst);
		table_rsp_t r;
		r.status = st;
		r.handle = h;
		r.key_first = k1;
		r.key_second = k2;
		r.label = lb;
		r.last = lst;
		expected_rsps.push_back(r);
	endfunction

	// Works out the answers to one request and updates the shadow table
	function automatic void predict_table_answers(table_req_t r);
		int i;
		if (r.cmd == CMD_LIST) begin
			if (shadow_count == 0) begin
				push_rsp(ST_EMPTY, '0, '0, '0, '0, 1'b1);
			end else begin
				for (i = 0; i < shadow_count; i++)
					push_rsp(ST_LISTED, shadow_handle[i], shadow_key_first[i],
						shadow_key_second[i], shadow_label[i], i == shadow_count - 1);
			end
			return;
		end
		for (i = 0; i < shadow_count; i++) begin
			if ((!shadow_label_mode || shadow_label[i] == r.label) &&
					shadow_key_first[i] == r.key_first &&
					shadow_key_second[i] == r.key_second) begin
				push_rsp(ST_FOUND, shadow_handle[i], '0, '0, '0, 1'b1);
				return;
			end
		end
		if (!r.learn) begin
			push_rsp(ST_ABSENT, '0, '0, '0, '0, 1'b1);
		end else if (shadow_count >= DEPTH_DEFAULT) begin
			push_rsp(ST_FULL, '0, '0, '0, '0, 1'b1);
		end else begin
			shadow_label[shadow_count] = shadow_label_mode ? r.label : LABEL_NONE;
			shadow_key_first[shadow_count] = r.key_first;
			shadow_key_second[shadow_count] = r.key_second;
			shadow_handle[shadow_count] = r.new_handle;
			shadow_count++;
			push_rsp(ST_INSERTED, r.new_handle, '0, '0, '0, 1'b1);
		end
	endfunction

	function automatic void add_req(logic c, logic signed [LABEL_W-1:0] lb,
			logic signed [KEY_W-1:0] k1, logic signed [KEY_W-1:0] k2, logic ln,
			logic [HANDLE_PORT_W-1:0] h);
		table_req_t r;
		r.cmd = c;
		r.label = lb;
		r.key_first = k1;
		r.key_second = k2;
		r.learn = ln;
		r.new_handle = h;
		pending_reqs.push_back(r);
		seen_keys.push_back(r);
	endfunction

	// Mostly repeats of earlier key pairs and fresh inserts; table fills and stays full
	function automatic void queue_random_reqs(int count);
		table_req_t r;
		table_req_t old;
		int n;
		int sel;
		for (n = 0; n < count; n++) begin
			sel = $urandom_range(99);
			r.cmd = CMD_LOOKUP;
			r.label = LABEL_W'($urandom);
			r.key_first = $urandom;
			r.key_second = $urandom;
			r.learn = 1'($urandom_range(1));
			r.new_handle = HANDLE_PORT_W'($urandom);
			if (sel < 7) begin
				r.cmd = CMD_LIST;
			end else if (sel < 50) begin
				old = seen_keys[$urandom_range(seen_keys.size() - 1)];
				r.key_first = old.key_first;
				r.key_second = old.key_second;
				if ($urandom_range(3) != 0)
					r.label = old.label;
				// near miss: one key off by a single bit
				if (sel < 14) begin
					if ($urandom_range(1))
						r.key_first[$urandom_range(KEY_W - 1)] ^= 1'b1;
					else
						r.key_second[$urandom_range(KEY_W - 1)] ^= 1'b1;
				end
			end else if (sel < 88) begin
				r.learn = 1'b1;
			end
			add_req(r.cmd, r.label, r.key_first, r.key_second, r.learn, r.new_handle);
		end
	endfunction

	function automatic void check_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
			errors++;
		end
	endfunction

	task automatic write_label_mode(input logic v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= LABEL_MODE_ADDR;
		pwdata <= {31'b0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		shadow_label_mode = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	// Request driver
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			predict_table_answers(pending_reqs[0]);
			void'(pending_reqs.pop_front());
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			req_taken = 1'b0;
			if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				req_valid <= 1'b1;
				cmd <= pending_reqs[0].cmd;
				label <= pending_reqs[0].label;
				key_first <= pending_reqs[0].key_first;
				key_second <= pending_reqs[0].key_second;
				learn <= pending_reqs[0].learn;
				new_handle <= pending_reqs[0].new_handle;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side: random stalls plus one long hold-off in the last segment
	always @(negedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result, status %0d handle %0h last %0b",
					$time, status, handle_out, last);
				errors++;
			end else begin
				rsp_exp = expected_rsps.pop_front();
				check_field("status", 64'(rsp_exp.status), 64'(status));
				check_field("handle_out", 64'(rsp_exp.handle), 64'(handle_out));
				check_field("key_first_out", 64'(rsp_exp.key_first), 64'(key_first_out));
				check_field("key_second_out", 64'(rsp_exp.key_second), 64'(key_second_out));
				check_field("label_out", 64'(rsp_exp.label), 64'(label_out));
				check_field("last", 64'(rsp_exp.last), 64'(last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= NO_ACCEPT_LIMIT) begin
					$display("%0t: no request or result moved for %0d cycles",
						$time, NO_ACCEPT_LIMIT);
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		sender_idle_pct = 11;
		receiver_idle_pct = 49;
		write_label_mode(1'b0);
		// labels ignored: extremes of keys, labels and handles
		add_req(CMD_LIST, 8'sd0, 32'sd0, 32'sd0, 1'b0, 16'h0);
		add_req(CMD_LOOKUP, 8'sd3, 32'sd5, 32'sd6, 1'b0, 16'h1);
		add_req(CMD_LOOKUP, -8'sd128, 32'h8000_0000, 32'h8000_0000, 1'b1, 16'h0000);
		add_req(CMD_LOOKUP, 8'sd127, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 16'hffff);
		add_req(CMD_LOOKUP, 8'sd0, 32'sd0, 32'sd0, 1'b1, 16'h1234);
		add_req(CMD_LOOKUP, -8'sd1, -32'sd1, -32'sd1, 1'b1, 16'h8000);
		add_req(CMD_LOOKUP, 8'sd1, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 16'h7fff);
		add_req(CMD_LOOKUP, 8'sd0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 16'h2);
		add_req(CMD_LOOKUP, 8'sd9, 32'h8000_0000, 32'h8000_0000, 1'b1, 16'h3);
		add_req(CMD_LOOKUP, 8'sd0, 32'h8000_0000, 32'sd0, 1'b0, 16'h4);
		add_req(CMD_LOOKUP, 8'sd0, 32'sd0, 32'h7fff_ffff, 1'b0, 16'h5);
		add_req(CMD_LIST, 8'sd0, 32'sd0, 32'sd0, 1'b0, 16'h0);
		wait_drained();

		// label mode: old entries carry the no-label value
		write_label_mode(1'b1);
		add_req(CMD_LOOKUP, 8'sd0, 32'sd0, 32'sd0, 1'b0, 16'h6);
		add_req(CMD_LOOKUP, -8'sd1, 32'sd0, 32'sd0, 1'b0, 16'h7);
		add_req(CMD_LOOKUP, 8'sd127, 32'sd0, 32'sd0, 1'b1, 16'h00ff);
		add_req(CMD_LOOKUP, 8'sd127, 32'sd0, 32'sd0, 1'b0, 16'h8);
		add_req(CMD_LOOKUP, -8'sd128, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 16'h5555);
		add_req(CMD_LOOKUP, -8'sd128, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 16'h9);
		add_req(CMD_LIST, 8'sd0, 32'sd0, 32'sd0, 1'b0, 16'h0);
		queue_random_reqs(RANDOM_PER_SEGMENT);
		wait_drained();

		write_label_mode(1'b0);
		sender_idle_pct = 49;
		receiver_idle_pct = 11;
		queue_random_reqs(RANDOM_PER_SEGMENT);
		wait_drained();

		write_label_mode(1'b1);
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_trigger++;
		queue_random_reqs(RANDOM_PER_SEGMENT);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
